// File: hdl/lav_pkg.sv
// Shared types, codes and latency figures of the look-at view matrix block.
package lav_pkg;

    typedef enum logic [1:0] {
        ROW_LEFT = 2'd0,
        ROW_UP   = 2'd1,
        ROW_BACK = 2'd2,
        ROW_UNIT = 2'd3
    } t_row;

    // register stages of lav_norm, input register to output register
    function automatic int norm_lat(input int frac_bits);
        return frac_bits + 41;
    endfunction

endpackage

// File: hdl/lav_in_if.sv
// Input channel: eye, target and up vector, one word per item.
interface lav_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;

    modport source (
        output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
               up_x, up_y, up_z,
        input  ready
    );
    modport sink (
        input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
               up_x, up_y, up_z,
        output ready
    );
endinterface

// File: hdl/lav_out_if.sv
// Output channel: one matrix row per word.
interface lav_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         row_index;
    logic signed [31:0] col_zero;
    logic signed [31:0] col_one;
    logic signed [31:0] col_two;
    logic signed [31:0] col_three;
    logic               last_row;
    logic               degenerate;

    modport source (
        output valid, row_index, col_zero, col_one, col_two, col_three,
               last_row, degenerate,
        input  ready
    );
    modport sink (
        input  valid, row_index, col_zero, col_one, col_two, col_three,
               last_row, degenerate,
        output ready
    );
endinterface

// File: hdl/lav_norm.sv
// Pipelined 3-vector normalizer: scale, square sum, bit-serial root, long division.
module lav_norm #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [32:0]         i_vec  [3],
    output logic signed [FRAC_BITS+1:0] o_vec [3],
    output logic                       o_zero
);
    localparam int QW = FRAC_BITS + 2;
    localparam int QB = FRAC_BITS + 1;
    localparam int NW = FRAC_BITS + 33;
    localparam int DS = FRAC_BITS + 1;
    localparam int SQ = 32;

    // magnitudes
    logic [32:0] r0_m [3];
    logic [2:0]  r0_neg;
    // scaling
    logic [30:0] r1_m [3];
    logic [30:0] r1_mx;
    logic [2:0]  r1_neg;
    logic        r1_zero;
    logic [30:0] r2_m [3];
    logic [30:0] r2_mx;
    logic [2:0]  r2_neg;
    logic        r2_zero;
    logic [30:0] r3_m [3];
    logic [2:0]  r3_neg;
    logic        r3_zero;
    // squares
    logic [61:0] r4_sq [3];
    logic [30:0] r4_m [3];
    logic [2:0]  r4_neg;
    logic        r4_zero;
    // root
    logic [63:0] r_sx   [0:SQ];
    logic [63:0] r_sr   [0:SQ];
    logic [30:0] r_sm   [0:SQ][3];
    logic [2:0]  r_sneg [0:SQ];
    logic        r_szero[0:SQ];
    logic [63:0] n_sx   [1:SQ];
    logic [63:0] n_sr   [1:SQ];
    // division
    logic [NW-1:0] r_drem [0:DS][3];
    logic [QB-1:0] r_dq   [0:DS][3];
    logic [31:0]   r_dlen [0:DS];
    logic [2:0]    r_dneg [0:DS];
    logic          r_dzero[0:DS];
    logic [NW-1:0] n_drem [1:DS][3];
    logic [QB-1:0] n_dq   [1:DS][3];
    // result
    logic signed [QW-1:0] r_out [3];
    logic                 r_zero;

    logic [30:0] n1_m [3];
    logic [30:0] n1_mx;
    logic [30:0] n2_m [3];
    logic [30:0] n2_mx;
    logic [30:0] n3_m [3];

    always_comb begin : c_scale1
        logic [32:0] mx;
        logic [1:0]  rs;
        logic [30:0] t;
        logic        l16;
        mx = r0_m[0];
        if (r0_m[1] > mx) mx = r0_m[1];
        if (r0_m[2] > mx) mx = r0_m[2];
        rs = mx[32] ? 2'd2 : (mx[31] ? 2'd1 : 2'd0);
        t = 31'(mx >> rs);
        l16 = (t[30:15] == '0);
        n1_mx = l16 ? (t << 16) : t;
        for (int i = 0; i < 3; i++) begin
            t = 31'(r0_m[i] >> rs);
            n1_m[i] = l16 ? (t << 16) : t;
        end
    end

    always_comb begin : c_scale2
        logic l8;
        logic l4;
        logic [30:0] t;
        l8 = (r1_mx[30:23] == '0);
        t = l8 ? (r1_mx << 8) : r1_mx;
        l4 = (t[30:27] == '0);
        n2_mx = l4 ? (t << 4) : t;
        for (int i = 0; i < 3; i++) begin
            t = l8 ? (r1_m[i] << 8) : r1_m[i];
            n2_m[i] = l4 ? (t << 4) : t;
        end
    end

    always_comb begin : c_scale3
        logic l2;
        logic l1;
        logic [30:0] t;
        l2 = (r2_mx[30:29] == '0);
        t = l2 ? (r2_mx << 2) : r2_mx;
        l1 = !t[30];
        for (int i = 0; i < 3; i++) begin
            t = l2 ? (r2_m[i] << 2) : r2_m[i];
            n3_m[i] = l1 ? (t << 1) : t;
        end
    end

    // one root bit per stage
    always_comb begin
        for (int j = 1; j <= SQ; j++) begin
            logic [63:0] bitv;
            logic [63:0] trial;
            bitv = 64'd1 << (62 - 2 * (j - 1));
            trial = r_sr[j-1] + bitv;
            if (r_sx[j-1] >= trial) begin
                n_sx[j] = r_sx[j-1] - trial;
                n_sr[j] = (r_sr[j-1] >> 1) + bitv;
            end else begin
                n_sx[j] = r_sx[j-1];
                n_sr[j] = r_sr[j-1] >> 1;
            end
        end
    end

    // one quotient bit per stage
    always_comb begin
        for (int d = 1; d <= DS; d++) begin
            for (int i = 0; i < 3; i++) begin
                logic [NW-1:0] sub;
                sub = NW'(r_dlen[d-1]) << (DS - d);
                n_drem[d][i] = r_drem[d-1][i];
                n_dq[d][i] = r_dq[d-1][i];
                if (r_drem[d-1][i] >= sub) begin
                    n_drem[d][i] = r_drem[d-1][i] - sub;
                    n_dq[d][i][DS-d] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r0_neg[i] <= i_vec[i][32];
                r0_m[i] <= i_vec[i][32] ? 33'(-i_vec[i]) : 33'(i_vec[i]);
            end
            r1_m <= n1_m;
            r1_mx <= n1_mx;
            r1_neg <= r0_neg;
            r1_zero <= (r0_m[0] == '0) && (r0_m[1] == '0) && (r0_m[2] == '0);
            r2_m <= n2_m;
            r2_mx <= n2_mx;
            r2_neg <= r1_neg;
            r2_zero <= r1_zero;
            r3_m <= n3_m;
            r3_neg <= r2_neg;
            r3_zero <= r2_zero;
            for (int i = 0; i < 3; i++) begin
                r4_sq[i] <= 62'(r3_m[i]) * 62'(r3_m[i]);
            end
            r4_m <= r3_m;
            r4_neg <= r3_neg;
            r4_zero <= r3_zero;

            r_sx[0] <= 64'(r4_sq[0]) + 64'(r4_sq[1]) + 64'(r4_sq[2]);
            r_sr[0] <= '0;
            r_sm[0] <= r4_m;
            r_sneg[0] <= r4_neg;
            r_szero[0] <= r4_zero;
            for (int j = 1; j <= SQ; j++) begin
                r_sx[j] <= n_sx[j];
                r_sr[j] <= n_sr[j];
                r_sm[j] <= r_sm[j-1];
                r_sneg[j] <= r_sneg[j-1];
                r_szero[j] <= r_szero[j-1];
            end

            for (int i = 0; i < 3; i++) begin
                r_drem[0][i] <= (NW'(r_sm[SQ][i]) << FRAC_BITS)
                              + NW'(r_sr[SQ][31:0] >> 1);
                r_dq[0][i] <= '0;
            end
            r_dlen[0] <= r_sr[SQ][31:0];
            r_dneg[0] <= r_sneg[SQ];
            r_dzero[0] <= r_szero[SQ];
            for (int d = 1; d <= DS; d++) begin
                r_drem[d] <= n_drem[d];
                r_dq[d] <= n_dq[d];
                r_dlen[d] <= r_dlen[d-1];
                r_dneg[d] <= r_dneg[d-1];
                r_dzero[d] <= r_dzero[d-1];
            end

            for (int i = 0; i < 3; i++) begin
                if (r_dzero[DS]) begin
                    r_out[i] <= '0;
                end else if (r_dneg[DS][i]) begin
                    r_out[i] <= -$signed(QW'(r_dq[DS][i]));
                end else begin
                    r_out[i] <= $signed(QW'(r_dq[DS][i]));
                end
            end
            r_zero <= r_dzero[DS];
        end
    end

    assign o_vec = r_out;
    assign o_zero = r_zero;

endmodule

// File: hdl/look_at_view_matrix.sv
// Look-at view matrix builder: top level.
//
// i_in takes one word per camera: eye point, target point and up vector, all
// signed Q(32-FRAC_BITS).FRAC_BITS. o_out returns the 4x4 view matrix as four
// words, rows 0 to 3 in order, last_row high on row 3 and degenerate high on
// all four rows when target equals eye or up is zero.
// Row 0 appears once the input word has passed the input register, the
// normalizer (scaling, squares, a 32-stage root and a FRAC_BITS+1 stage
// divider) and registers r1 to r6; rows 1 to 3 follow as each row is taken.
// Throughput is set by the four rows per word on the output channel; inputs
// may arrive every cycle while the pipeline advances and queue in it.
// The whole pipeline advances together; i_in.ready is high while the output
// register is empty or its last row is being taken.
// When the receiver holds o_out.ready low the current row is held, the
// pipeline freezes and nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous) empties the pipeline; no clearing pass.
module look_at_view_matrix #(
    parameter int FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lav_in_if.sink     i_in,
    lav_out_if.source  o_out
);
    localparam int NL  = lav_pkg::norm_lat(FRAC_BITS);
    localparam int VL  = NL + 6;
    localparam int EL  = NL + 4;
    localparam int QW  = FRAC_BITS + 2;
    localparam int LW  = FRAC_BITS + 3;
    localparam int TW  = FRAC_BITS + 4;
    localparam int P1W = 2 * QW;
    localparam int P1X = P1W + 1;
    localparam int P2W = LW + QW;
    localparam int P2X = P2W + 1;
    localparam int DW  = TW + 32;
    localparam int SW  = DW + 2;
    localparam int HALF_Q = 1 << (FRAC_BITS - 1);
    localparam logic [31:0] ONE_Q = 32'd1 << FRAC_BITS;

    logic              r_v [0:VL];
    logic              adv;
    lav_pkg::t_row     r_row;

    logic signed [31:0] r_eye  [0:EL][3];
    logic signed [32:0] r0_diff [3];
    logic signed [32:0] r0_up   [3];

    logic signed [QW-1:0] w_fwd [3];
    logic signed [QW-1:0] w_upn [3];
    logic                 w_zf;
    logic                 w_zu;

    logic signed [P1W-1:0] r1_p [6];
    logic signed [QW-1:0]  r1_fwd [3];
    logic                  r1_dg;
    logic signed [LW-1:0]  r2_left [3];
    logic signed [QW-1:0]  r2_fwd [3];
    logic                  r2_dg;
    logic signed [P2W-1:0] r3_p [6];
    logic signed [LW-1:0]  r3_left [3];
    logic signed [QW-1:0]  r3_fwd [3];
    logic                  r3_dg;
    logic signed [TW-1:0]  r4_tup [3];
    logic signed [LW-1:0]  r4_left [3];
    logic signed [QW-1:0]  r4_fwd [3];
    logic                  r4_dg;
    logic signed [DW-1:0]  r5_dot [9];
    logic signed [TW-1:0]  r5_tup [3];
    logic signed [LW-1:0]  r5_left [3];
    logic signed [QW-1:0]  r5_fwd [3];
    logic                  r5_dg;
    logic signed [TW-1:0]  r6_tup [3];
    logic signed [LW-1:0]  r6_left [3];
    logic signed [QW-1:0]  r6_fwd [3];
    logic signed [31:0]    r6_c3 [3];
    logic                  r6_dg;

    logic signed [LW-1:0]  n2_left [3];
    logic signed [TW-1:0]  n4_tup [3];
    logic signed [31:0]    n6_c3 [3];

    assign adv = !r_v[VL] || (o_out.ready && (r_row == lav_pkg::ROW_UNIT));
    assign i_in.ready = adv;

    lav_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_fwd (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_vec  (r0_diff),
        .o_vec  (w_fwd),
        .o_zero (w_zf)
    );

    lav_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_up (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_vec  (r0_up),
        .o_vec  (w_upn),
        .o_zero (w_zu)
    );

    // cross product rounding
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [P1X-1:0] d1;
            logic signed [P2X-1:0] d2;
            d1 = P1X'(r1_p[2*i]) - P1X'(r1_p[2*i+1]) + P1X'(HALF_Q);
            n2_left[i] = LW'(d1 >>> FRAC_BITS);
            d2 = P2X'(r3_p[2*i]) - P2X'(r3_p[2*i+1]) + P2X'(HALF_Q);
            n4_tup[i] = TW'(d2 >>> FRAC_BITS);
        end
    end

    // translation column: -round(row . eye), saturated
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            logic signed [SW-1:0] s;
            logic signed [SW-1:0] t;
            logic signed [SW-1:0] ng;
            s = SW'(r5_dot[3*r]) + SW'(r5_dot[3*r+1]) + SW'(r5_dot[3*r+2]);
            if (r == 2) begin
                s = -s;
            end
            t = (s + SW'(HALF_Q)) >>> FRAC_BITS;
            ng = -t;
            if ((ng[SW-1:31] == '0) || (ng[SW-1:31] == '1)) begin
                n6_c3[r] = ng[31:0];
            end else begin
                n6_c3[r] = ng[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= VL; k++) begin
                r_v[k] <= 1'b0;
            end
            r_row <= lav_pkg::ROW_LEFT;
        end else begin
            if (adv) begin
                r_v[0] <= i_in.valid;
                for (int k = 1; k <= VL; k++) begin
                    r_v[k] <= r_v[k-1];
                end
                r_row <= lav_pkg::ROW_LEFT;
            end else if (o_out.ready) begin
                r_row <= lav_pkg::t_row'(r_row + 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_eye[0][0] <= i_in.eye_x;
            r_eye[0][1] <= i_in.eye_y;
            r_eye[0][2] <= i_in.eye_z;
            r0_diff[0] <= 33'(i_in.target_x) - 33'(i_in.eye_x);
            r0_diff[1] <= 33'(i_in.target_y) - 33'(i_in.eye_y);
            r0_diff[2] <= 33'(i_in.target_z) - 33'(i_in.eye_z);
            r0_up[0] <= 33'(i_in.up_x);
            r0_up[1] <= 33'(i_in.up_y);
            r0_up[2] <= 33'(i_in.up_z);
            for (int k = 1; k <= EL; k++) begin
                r_eye[k] <= r_eye[k-1];
            end

            r1_p[0] <= w_fwd[1] * w_upn[2];
            r1_p[1] <= w_fwd[2] * w_upn[1];
            r1_p[2] <= w_fwd[2] * w_upn[0];
            r1_p[3] <= w_fwd[0] * w_upn[2];
            r1_p[4] <= w_fwd[0] * w_upn[1];
            r1_p[5] <= w_fwd[1] * w_upn[0];
            r1_fwd <= w_fwd;
            r1_dg <= w_zf || w_zu;

            r2_left <= n2_left;
            r2_fwd <= r1_fwd;
            r2_dg <= r1_dg;

            r3_p[0] <= r2_left[1] * r2_fwd[2];
            r3_p[1] <= r2_left[2] * r2_fwd[1];
            r3_p[2] <= r2_left[2] * r2_fwd[0];
            r3_p[3] <= r2_left[0] * r2_fwd[2];
            r3_p[4] <= r2_left[0] * r2_fwd[1];
            r3_p[5] <= r2_left[1] * r2_fwd[0];
            r3_left <= r2_left;
            r3_fwd <= r2_fwd;
            r3_dg <= r2_dg;

            r4_tup <= n4_tup;
            r4_left <= r3_left;
            r4_fwd <= r3_fwd;
            r4_dg <= r3_dg;

            for (int i = 0; i < 3; i++) begin
                r5_dot[i]     <= r4_left[i] * r_eye[EL][i];
                r5_dot[3 + i] <= r4_tup[i] * r_eye[EL][i];
                r5_dot[6 + i] <= r4_fwd[i] * r_eye[EL][i];
            end
            r5_tup <= r4_tup;
            r5_left <= r4_left;
            r5_fwd <= r4_fwd;
            r5_dg <= r4_dg;

            r6_c3 <= n6_c3;
            r6_tup <= r5_tup;
            r6_left <= r5_left;
            r6_fwd <= r5_fwd;
            r6_dg <= r5_dg;
        end
    end

    always_comb begin
        o_out.valid = r_v[VL];
        o_out.row_index = r_row;
        o_out.last_row = (r_row == lav_pkg::ROW_UNIT);
        o_out.degenerate = r6_dg;
        case (r_row)
            lav_pkg::ROW_LEFT: begin
                o_out.col_zero  = 32'(r6_left[0]);
                o_out.col_one   = 32'(r6_left[1]);
                o_out.col_two   = 32'(r6_left[2]);
                o_out.col_three = r6_c3[0];
            end
            lav_pkg::ROW_UP: begin
                o_out.col_zero  = 32'(r6_tup[0]);
                o_out.col_one   = 32'(r6_tup[1]);
                o_out.col_two   = 32'(r6_tup[2]);
                o_out.col_three = r6_c3[1];
            end
            lav_pkg::ROW_BACK: begin
                o_out.col_zero  = -32'(r6_fwd[0]);
                o_out.col_one   = -32'(r6_fwd[1]);
                o_out.col_two   = -32'(r6_fwd[2]);
                o_out.col_three = r6_c3[2];
            end
            default: begin
                o_out.col_zero  = '0;
                o_out.col_one   = '0;
                o_out.col_two   = '0;
                o_out.col_three = ONE_Q;
            end
        endcase
    end

    a_row_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row != lav_pkg::ROW_LEFT) |-> r_v[VL])
        else $error("row counter running without a held word");

    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && (r_row != lav_pkg::ROW_UNIT))
        |=> (o_out.valid && (r_row == $past(r_row) + 2'd1)))
        else $error("row sequence broken");

    a_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[VL] && !(o_out.ready && (r_row == lav_pkg::ROW_UNIT)))
        |=> (r_v[VL] && $stable(r6_c3[0]) && $stable(r6_dg)))
        else $error("word left output stage before its last row");

endmodule

// File: tb/lav_tb_pkg.sv
// Testbench-side row record shared by the view matrix bench.
package lav_tb_pkg;

    typedef struct packed {
        lav_pkg::t_row      row_index;
        logic signed [31:0] col_zero;
        logic signed [31:0] col_one;
        logic signed [31:0] col_two;
        logic signed [31:0] col_three;
        logic               last_row;
        logic               degenerate;
    } t_row_word;
endpackage

// File: tb/testbench.sv
// Self-checking bench for look_at_view_matrix: directed and random cameras.
module testbench;

    localparam int FB = 16;
    localparam int LAT = FB + 47;

    logic i_clk;
    logic i_rst_n;
    lav_in_if  cam_ch();
    lav_out_if row_ch();

    look_at_view_matrix #(.FRAC_BITS(FB)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(cam_ch.sink), .o_out(row_ch.source)
    );

    lav_tb_pkg::t_row_word expected_rows[$];
    int  n_errors = 0;
    int  n_cams = 0;
    int  n_rows = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_on = 0;
    bit  in_reset = 1;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic logic signed [63:0] rnd_q(input logic signed [63:0] v);
        logic signed [63:0] w;
        w = v + (64'sd1 <<< (FB - 1));
        return w >>> FB;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // unit vector; returns 0 on zero length
    function automatic bit unit_vec(input logic signed [63:0] v[3],
                                    output logic signed [63:0] u[3]);
        logic [63:0] m[3];
        logic [63:0] mx, s, len, q;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
            u[i] = 0;
        end
        if (mx == 0) return 0;
        while (mx >= (64'd1 << 31)) begin
            for (int i = 0; i < 3; i++) m[i] >>= 1;
            mx >>= 1;
        end
        while (mx < (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] <<= 1;
            mx <<= 1;
        end
        s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FB) + (len >> 1)) / len;
            u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
        end
        return 1;
    endfunction

    function automatic void cross_q(input logic signed [63:0] a[3],
                                    input logic signed [63:0] b[3],
                                    output logic signed [63:0] r[3]);
        r[0] = rnd_q(a[1] * b[2] - a[2] * b[1]);
        r[1] = rnd_q(a[2] * b[0] - a[0] * b[2]);
        r[2] = rnd_q(a[0] * b[1] - a[1] * b[0]);
    endfunction

    task automatic predict_view_rows(input logic signed [31:0] cam[9]);
        logic signed [63:0] eye[3], dif[3], up[3], fw[3], un[3], lf[3], tu[3];
        logic signed [63:0] rw[3][3];
        logic signed [63:0] dot;
        bit dg;
        lav_tb_pkg::t_row_word w;
        for (int i = 0; i < 3; i++) begin
            eye[i] = cam[i];
            dif[i] = 64'(cam[3 + i]) - 64'(cam[i]);
            up[i] = cam[6 + i];
        end
        dg = !unit_vec(dif, fw);
        if (!unit_vec(up, un)) dg = 1;
        cross_q(fw, un, lf);
        cross_q(lf, fw, tu);
        for (int i = 0; i < 3; i++) begin
            rw[0][i] = lf[i];
            rw[1][i] = tu[i];
            rw[2][i] = -fw[i];
        end
        for (int r = 0; r < 3; r++) begin
            dot = rw[r][0] * eye[0] + rw[r][1] * eye[1] + rw[r][2] * eye[2];
            w.row_index = lav_pkg::t_row'(r);
            w.col_zero = sat32(rw[r][0]);
            w.col_one = sat32(rw[r][1]);
            w.col_two = sat32(rw[r][2]);
            w.col_three = sat32(-rnd_q(dot));
            w.last_row = 0;
            w.degenerate = dg;
            expected_rows.push_back(w);
        end
        w.row_index = lav_pkg::ROW_UNIT;
        w.col_zero = 0;
        w.col_one = 0;
        w.col_two = 0;
        w.col_three = 32'sd1 <<< FB;
        w.last_row = 1;
        w.degenerate = dg;
        expected_rows.push_back(w);
    endtask

    // ---------------- receiver ----------------
    initial row_ch.ready = 0;

    always @(posedge i_clk) begin
        if (in_reset) begin
            row_ch.ready <= 0;
        end else if (hold_on) begin
            row_ch.ready <= 0;
        end else begin
            row_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        lav_tb_pkg::t_row_word e;
        if (!in_reset && row_ch.valid && row_ch.ready) begin
            n_rows++;
            if (expected_rows.size() == 0) begin
                $error("row word with nothing expected");
                n_errors++;
            end else begin
                e = expected_rows.pop_front();
                if (row_ch.row_index !== e.row_index) begin
                    $error("row_index exp %0d got %0d", e.row_index, row_ch.row_index);
                    n_errors++;
                end
                if (row_ch.col_zero !== e.col_zero) begin
                    $error("col_zero exp %0d got %0d", e.col_zero, row_ch.col_zero);
                    n_errors++;
                end
                if (row_ch.col_one !== e.col_one) begin
                    $error("col_one exp %0d got %0d", e.col_one, row_ch.col_one);
                    n_errors++;
                end
                if (row_ch.col_two !== e.col_two) begin
                    $error("col_two exp %0d got %0d", e.col_two, row_ch.col_two);
                    n_errors++;
                end
                if (row_ch.col_three !== e.col_three) begin
                    $error("col_three exp %0d got %0d", e.col_three, row_ch.col_three);
                    n_errors++;
                end
                if (row_ch.last_row !== e.last_row) begin
                    $error("last_row exp %0d got %0d", e.last_row, row_ch.last_row);
                    n_errors++;
                end
                if (row_ch.degenerate !== e.degenerate) begin
                    $error("degenerate exp %0d got %0d", e.degenerate, row_ch.degenerate);
                    n_errors++;
                end
            end
        end
    end

    // ---------------- sender ----------------
    task automatic send_cam(input logic signed [31:0] cam[9]);
        while ($urandom_range(99) < send_idle_pct) begin
            cam_ch.valid <= 0;
            @(posedge i_clk);
        end
        cam_ch.valid <= 1;
        cam_ch.eye_x <= cam[0];
        cam_ch.eye_y <= cam[1];
        cam_ch.eye_z <= cam[2];
        cam_ch.target_x <= cam[3];
        cam_ch.target_y <= cam[4];
        cam_ch.target_z <= cam[5];
        cam_ch.up_x <= cam[6];
        cam_ch.up_y <= cam[7];
        cam_ch.up_z <= cam[8];
        do @(posedge i_clk); while (!cam_ch.ready);
        predict_view_rows(cam);
        n_cams++;
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $signed($urandom_range(32'h7ffff)) - 32'sh40000;
            2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            3: return 0;
            default: return $signed($urandom) >>> $urandom_range(20);
        endcase
    endfunction

    task automatic send_random(input int n);
        logic signed [31:0] cam[9];
        for (int k = 0; k < n; k++) begin
            foreach (cam[i]) cam[i] = rand_coord();
            case ($urandom_range(9))
                0: for (int i = 0; i < 3; i++) cam[3 + i] = cam[i];
                1: for (int i = 0; i < 3; i++) cam[6 + i] = 0;
                2: for (int i = 0; i < 3; i++) cam[6 + i] = cam[3 + i] - cam[i];
                default: ;
            endcase
            send_cam(cam);
        end
    endtask

    task automatic test_directed();
        logic signed [31:0] cam[9];
        logic signed [31:0] ext[4];
        ext = '{32'sh7fffffff, 32'sh80000000, 0, 32'sh10000};
        // plain camera looking down -z, y up
        cam = '{0, 0, 32'sh50000, 0, 0, 0, 0, 32'sh10000, 0};
        send_cam(cam);
        // eye equals target
        cam = '{32'sh12345, 7, -3, 32'sh12345, 7, -3, 0, 32'sh10000, 0};
        send_cam(cam);
        // zero up
        cam = '{1, 2, 3, 32'sh40000, 5, 6, 0, 0, 0};
        send_cam(cam);
        // both zero
        cam = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_cam(cam);
        // up parallel to forward
        cam = '{0, 0, 0, 0, 32'sh30000, 0, 0, 32'sh10000, 0};
        send_cam(cam);
        for (int a = 0; a < 4; a++) begin
            for (int b = 0; b < 4; b++) begin
                for (int i = 0; i < 3; i++) begin
                    cam[i] = ext[a];
                    cam[3 + i] = ext[b];
                    cam[6 + i] = ext[(a + b + i) % 4];
                end
                cam[4] = ext[(b + 1) % 4];
                send_cam(cam);
            end
        end
        cam = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                32'sh80000000, 32'sh7fffffff, -1, -1, -1};
        send_cam(cam);
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_on <= 1;
                repeat (400) @(posedge i_clk);
                hold_on <= 0;
            end
            send_random(100);
        join
    endtask

    task automatic drain();
        cam_ch.valid <= 0;
        while (expected_rows.size() != 0) @(posedge i_clk);
        repeat (LAT + 8) @(posedge i_clk);
    endtask

    initial begin
        cam_ch.valid = 0;
        cam_ch.eye_x = 0;
        cam_ch.eye_y = 0;
        cam_ch.eye_z = 0;
        cam_ch.target_x = 0;
        cam_ch.target_y = 0;
        cam_ch.target_z = 0;
        cam_ch.up_x = 0;
        cam_ch.up_y = 0;
        cam_ch.up_z = 0;
        i_rst_n = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        in_reset <= 0;
        @(posedge i_clk);

        test_directed();
        send_idle_pct = 35;
        recv_idle_pct = 64;
        send_random(120);
        send_idle_pct = 64;
        recv_idle_pct = 35;
        send_random(120);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        send_random(50);
        drain();

        $display("Covered %0d cameras, %0d rows: extremes, degenerate and parallel cases,",
                 n_cams, n_rows);
        $display("random coordinates under idling on both sides and a long output stall.");
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
